/* rtl/core/obb_overlap_test_2d_defines.svh */
// Assertion macros shared by the oriented-box overlap tester RTL.
`ifndef OBB_OVERLAP_TEST_2D_DEFINES_SVH
`define OBB_OVERLAP_TEST_2D_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OBB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/obbot_pkg.sv */
// Shared types and constants of the oriented-box overlap tester.
package obbot_pkg;

    // Opcode of an input word
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    // Width of the slot fields on the ports
    localparam int SLOT_FIELD_W = 4;
    localparam int SLOT_CODES   = 1 << SLOT_FIELD_W;

    // Largest positive Q16.16 distance or radius
    localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

    // One box as held in the table
    typedef struct packed {
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [15:0] axis_u_x;
        logic [15:0] axis_u_y;
        logic [15:0] axis_v_x;
        logic [15:0] axis_v_y;
        logic [30:0] half_len_u;
        logic [30:0] half_len_v;
    } box_t;

    // Tag of the product issued to the shared multiplier
    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_DIST0,
        MOP_DIST1,
        MOP_DOT0,
        MOP_DOT1,
        MOP_DOT2,
        MOP_DOT3,
        MOP_RAD0,
        MOP_RAD1
    } mop_t;

    // Sequencer to arithmetic unit
    typedef struct packed {
        mop_t op;
        logic clr;
    } alu_ctl_t;

    // Arithmetic unit to sequencer
    typedef struct packed {
        logic busy;
        logic sep;
    } alu_sts_t;

endpackage

/* rtl/core/obbot_box_mem.sv */
// Box table: one write port, one read port with registered read data.
module obbot_box_mem #(
    parameter int BOX_SLOTS = 16,
    localparam int IDX_W = $clog2(BOX_SLOTS)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  obbot_pkg::box_t  wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output obbot_pkg::box_t  rd_data
);
    import obbot_pkg::*;

    box_t mem [BOX_SLOTS];
    box_t rd_data_reg;

    // Write a box word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read and hold until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/obbot_alu.sv */
// Shared multiplier with the accumulate, saturate and compare stage behind it.
module obbot_alu #(
    parameter int AXIS_FRAC_BITS = 14,
    localparam int B_W = 33 - AXIS_FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  obbot_pkg::alu_ctl_t    ctl,
    input  logic signed [31:0]     opnd_a,
    input  logic signed [B_W-1:0]  opnd_b,
    input  logic [30:0]            half_len,
    output obbot_pkg::alu_sts_t    sts
);
    import obbot_pkg::*;

    localparam int P_W   = 32 + B_W;
    localparam int S_W   = P_W - AXIS_FRAC_BITS;
    localparam int ACC_W = S_W + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, POS_MAX};
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;
    localparam logic signed [S_W-1:0]   TERM_HI = {{(S_W-31){1'b0}}, POS_MAX};

    mop_t                  op_reg;
    logic                  sep_reg;
    logic signed [P_W-1:0] prod_reg;
    logic signed [P_W-1:0] prod_next;
    logic signed [S_W-1:0] dacc_reg;
    logic [30:0]           dist_reg;
    logic [30:0]           dist_next;
    logic signed [B_W-1:0] dot0_reg;
    logic signed [B_W-1:0] dot1_reg;
    logic [31:0]           rad_reg;
    logic signed [B_W-1:0] dot0_mag;
    logic signed [B_W-1:0] dot1_mag;
    logic signed [B_W-1:0] mul_b;
    logic signed [S_W-1:0] sh;
    logic signed [B_W-1:0] dot_sh;
    logic signed [ACC_W-1:0] dsum;
    logic signed [ACC_W-1:0] dsum_abs;
    logic [30:0]           term;
    logic [32:0]           rad_total;
    logic                  sep_hit;

    // Pick the second operand: projected radius products take a dot magnitude
    assign dot0_mag = dot0_reg[B_W-1] ? -dot0_reg : dot0_reg;
    assign dot1_mag = dot1_reg[B_W-1] ? -dot1_reg : dot1_reg;

    always_comb
    begin
        case (ctl.op)
            MOP_RAD0: mul_b = dot0_mag;
            MOP_RAD1: mul_b = dot1_mag;
            default:  mul_b = opnd_b;
        endcase
    end

    assign prod_next = opnd_a * mul_b;

    // Scale the product back down, rounding toward minus infinity
    assign sh     = S_W'(prod_reg >>> AXIS_FRAC_BITS);
    assign dot_sh = B_W'(sh);

    // Center distance: saturate to 32 bits, take the magnitude, clamp
    assign dsum     = ACC_W'(dacc_reg) + ACC_W'(sh);
    assign dsum_abs = dsum[ACC_W-1] ? -dsum : dsum;

    always_comb
    begin
        if (dsum >= SAT_HI || dsum <= SAT_LO)
        begin
            dist_next = POS_MAX;
        end
        else
        begin
            dist_next = dsum_abs[30:0];
        end
    end

    // Radius term is never negative; clamp it
    assign term = (sh > TERM_HI) ? POS_MAX : sh[30:0];

    // Distance never exceeds the clamp, so the unclamped sum compares the same
    assign rad_total = {1'b0, rad_reg} + {2'b00, term};
    assign sep_hit   = {2'b00, dist_reg} > rad_total;

    // Track the tag of the product in flight and the sticky separation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= MOP_NONE;
            sep_reg <= 1'b0;
        end
        else
        begin
            op_reg <= ctl.op;
            if (ctl.clr)
            begin
                sep_reg <= 1'b0;
            end
            else if (op_reg == MOP_RAD1 && sep_hit)
            begin
                sep_reg <= 1'b1;
            end
        end
    end

    // Multiply, then fold the previous product into the running values
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (op_reg)
            MOP_DIST0: dacc_reg <= sh;
            MOP_DIST1: dist_reg <= dist_next;
            MOP_DOT0:  dot0_reg <= dot_sh;
            MOP_DOT1:  dot0_reg <= dot0_reg + dot_sh;
            MOP_DOT2:  dot1_reg <= dot_sh;
            MOP_DOT3:  dot1_reg <= dot1_reg + dot_sh;
            MOP_RAD0:  rad_reg  <= {1'b0, half_len} + {1'b0, term};
            default:   ;
        endcase
    end

    assign sts.busy = (op_reg != MOP_NONE);
    assign sts.sep  = sep_reg;

endmodule

/* rtl/core/obb_overlap_test_2d.sv */
// A store word leaves the block idle. A test word with an inactive box goes straight
// to ST_DONE. A test word with two active boxes takes two table reads (ST_LOAD_A,
// ST_LOAD_B), 32 products on the one multiplier (8 per axis) in ST_RUN, a drain in
// ST_FLUSH and the result in ST_DONE, which waits while the old result is stalled.
// in_stall is high while a test is in work. Reset clears all active flags and
// the control; box data is unknown until written.
module obb_overlap_test_2d #(
    parameter int BOX_SLOTS      = 16,
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [3:0]         slot,
    input  logic [3:0]         other_slot,
    input  logic               active,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [15:0] axis_u_x,
    input  logic signed [15:0] axis_u_y,
    input  logic signed [15:0] axis_v_x,
    input  logic signed [15:0] axis_v_y,
    input  logic [30:0]        half_len_u,
    input  logic [30:0]        half_len_v,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               overlap,
    output logic               any_inactive
);
    import obbot_pkg::*;

`include "obb_overlap_test_2d_defines.svh"

    localparam int IDX_W = $clog2(BOX_SLOTS);
    localparam int B_W   = 33 - AXIS_FRAC_BITS;

    // Steps of one axis on the shared multiplier
    localparam logic [2:0] STEP_DIST_X = 3'd0;
    localparam logic [2:0] STEP_DIST_Y = 3'd1;
    localparam logic [2:0] STEP_DOT_UX = 3'd2;
    localparam logic [2:0] STEP_DOT_UY = 3'd3;
    localparam logic [2:0] STEP_DOT_VX = 3'd4;
    localparam logic [2:0] STEP_DOT_VY = 3'd5;
    localparam logic [2:0] STEP_RAD_U  = 3'd6;
    localparam logic [2:0] STEP_RAD_V  = 3'd7;
    localparam logic [1:0] AXIS_LAST   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [2:0]            step_reg;
    logic [1:0]            axis_reg;
    logic                  inact_reg;
    logic                  out_valid_reg;
    logic                  overlap_reg;
    logic                  any_inactive_reg;
    logic [BOX_SLOTS-1:0]  active_reg;
    logic [IDX_W-1:0]      slot_b_reg;
    box_t                  box_a_reg;
    logic signed [31:0]    dx_reg;
    logic signed [31:0]    dy_reg;

    logic [IDX_W-1:0]      slot_map [SLOT_CODES];
    logic [IDX_W-1:0]      idx_a;
    logic [IDX_W-1:0]      idx_b;
    logic                  in_fire;
    logic                  store_go;
    logic                  test_go;
    logic                  both_active;
    logic                  out_free;
    box_t                  wr_box;
    box_t                  rd_box;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    box_t                  own_box;
    box_t                  oth_box;
    logic [15:0]           own_ax;
    logic [15:0]           own_ay;
    logic [30:0]           own_h;
    logic signed [B_W-1:0] ax_ext;
    logic signed [B_W-1:0] ay_ext;
    logic signed [31:0]    mul_a;
    logic signed [B_W-1:0] mul_b;
    alu_ctl_t              alu_ctl;
    alu_sts_t              alu_sts;

    // Fold the slot fields onto the table depth
    for (genvar g = 0; g < SLOT_CODES; g++)
    begin : g_slot_map
        assign slot_map[g] = IDX_W'(g % BOX_SLOTS);
    end

    assign idx_a = slot_map[slot];
    assign idx_b = slot_map[other_slot];

    function automatic logic [31:0] sub_sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31])
        begin
            return {d[32], {31{~d[32]}}};
        end
        return d[31:0];
    endfunction

    // Input handshake
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_fire     = in_valid && !in_stall;
    assign store_go    = in_fire && (opcode == OP_STORE);
    assign test_go     = in_fire && (opcode == OP_TEST);
    assign both_active = active_reg[idx_a] && active_reg[idx_b];
    assign out_free    = !out_valid_reg || !out_stall;

    // Box table
    assign wr_box.center_x   = center_x;
    assign wr_box.center_y   = center_y;
    assign wr_box.axis_u_x   = axis_u_x;
    assign wr_box.axis_u_y   = axis_u_y;
    assign wr_box.axis_v_x   = axis_v_x;
    assign wr_box.axis_v_y   = axis_v_y;
    assign wr_box.half_len_u = half_len_u;
    assign wr_box.half_len_v = half_len_v;

    assign rd_en   = (state_reg == ST_IDLE) || (state_reg == ST_LOAD_A);
    assign rd_addr = (state_reg == ST_IDLE) ? idx_a : slot_b_reg;

    obbot_box_mem #(
        .BOX_SLOTS (BOX_SLOTS)
    ) u_box_mem (
        .clk     (clk),
        .wr_en   (store_go),
        .wr_addr (idx_a),
        .wr_data (wr_box),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_box)
    );

    // Box b stays in the table read register through the whole run
    assign own_box = axis_reg[1] ? rd_box : box_a_reg;
    assign oth_box = axis_reg[1] ? box_a_reg : rd_box;
    assign own_ax  = axis_reg[0] ? own_box.axis_v_x : own_box.axis_u_x;
    assign own_ay  = axis_reg[0] ? own_box.axis_v_y : own_box.axis_u_y;
    assign own_h   = axis_reg[0] ? own_box.half_len_v : own_box.half_len_u;
    assign ax_ext  = {{(B_W-16){own_ax[15]}}, own_ax};
    assign ay_ext  = {{(B_W-16){own_ay[15]}}, own_ay};

    // Issue one product per run cycle
    always_comb
    begin
        alu_ctl.clr = test_go;
        alu_ctl.op  = MOP_NONE;
        mul_a       = dx_reg;
        mul_b       = ax_ext;
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                STEP_DIST_X:
                begin
                    alu_ctl.op = MOP_DIST0;
                    mul_a      = dx_reg;
                    mul_b      = ax_ext;
                end
                STEP_DIST_Y:
                begin
                    alu_ctl.op = MOP_DIST1;
                    mul_a      = dy_reg;
                    mul_b      = ay_ext;
                end
                STEP_DOT_UX:
                begin
                    alu_ctl.op = MOP_DOT0;
                    mul_a      = {{16{oth_box.axis_u_x[15]}}, oth_box.axis_u_x};
                    mul_b      = ax_ext;
                end
                STEP_DOT_UY:
                begin
                    alu_ctl.op = MOP_DOT1;
                    mul_a      = {{16{oth_box.axis_u_y[15]}}, oth_box.axis_u_y};
                    mul_b      = ay_ext;
                end
                STEP_DOT_VX:
                begin
                    alu_ctl.op = MOP_DOT2;
                    mul_a      = {{16{oth_box.axis_v_x[15]}}, oth_box.axis_v_x};
                    mul_b      = ax_ext;
                end
                STEP_DOT_VY:
                begin
                    alu_ctl.op = MOP_DOT3;
                    mul_a      = {{16{oth_box.axis_v_y[15]}}, oth_box.axis_v_y};
                    mul_b      = ay_ext;
                end
                STEP_RAD_U:
                begin
                    alu_ctl.op = MOP_RAD0;
                    mul_a      = {1'b0, oth_box.half_len_u};
                end
                STEP_RAD_V:
                begin
                    alu_ctl.op = MOP_RAD1;
                    mul_a      = {1'b0, oth_box.half_len_v};
                end
                default:
                begin
                    alu_ctl.op = MOP_NONE;
                end
            endcase
        end
    end

    obbot_alu #(
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (alu_ctl),
        .opnd_a   (mul_a),
        .opnd_b   (mul_b),
        .half_len (own_h),
        .sts      (alu_sts)
    );

    // Sequencer, active flags and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_DIST_X;
            axis_reg         <= '0;
            inact_reg        <= 1'b0;
            active_reg       <= '0;
            out_valid_reg    <= 1'b0;
            overlap_reg      <= 1'b0;
            any_inactive_reg <= 1'b0;
        end
        else
        begin
            // Drop the result word once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (store_go)
                    begin
                        active_reg[idx_a] <= active;
                    end
                    if (test_go)
                    begin
                        inact_reg <= !both_active;
                        step_reg  <= STEP_DIST_X;
                        axis_reg  <= '0;
                        state_reg <= both_active ? ST_LOAD_A : ST_DONE;
                    end
                end
                ST_LOAD_A:
                begin
                    state_reg <= ST_LOAD_B;
                end
                ST_LOAD_B:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == STEP_RAD_V)
                    begin
                        axis_reg <= axis_reg + 2'd1;
                        if (axis_reg == AXIS_LAST)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        overlap_reg      <= !inact_reg && !alu_sts.sep;
                        any_inactive_reg <= inact_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture the slot of box b, box a and the saturated center difference
    always_ff @(posedge clk)
    begin
        if (test_go)
        begin
            slot_b_reg <= idx_b;
        end
        if (state_reg == ST_LOAD_A)
        begin
            box_a_reg <= rd_box;
        end
        if (state_reg == ST_LOAD_B)
        begin
            dx_reg <= sub_sat32(box_a_reg.center_x, rd_box.center_x);
            dy_reg <= sub_sat32(box_a_reg.center_y, rd_box.center_y);
        end
    end

    assign out_valid    = out_valid_reg;
    assign overlap      = overlap_reg;
    assign any_inactive = any_inactive_reg;

    // Checks on the sequencer and the result word
    `OBB_ASSERT_NEXT(a_store_no_stall, store_go, !in_stall, "store word left the block busy")
    `OBB_ASSERT_NEXT(a_test_busy, test_go && both_active, in_stall, "active test did not start")
    `OBB_ASSERT_NOW(a_alu_in_run, alu_sts.busy, state_reg == ST_RUN || state_reg == ST_FLUSH, "product in flight outside a run")
    `OBB_ASSERT_NOW(a_result_code, out_valid, !(overlap && any_inactive), "overlap reported with an inactive box")

endmodule
